@@ src/imf_pkg.sv @@
package imf_pkg;

	localparam int CHANNELS   = 6;
	localparam int MAX_WINDOW = 8;
	localparam int SMP_W      = 16;
	localparam int OUT_W      = 24;
	localparam int CH_W       = 3;
	localparam int IDX_W      = 3;
	localparam int CNT_W      = 4;
	localparam int MEM_DEPTH  = CHANNELS * MAX_WINDOW;
	localparam int SUM_W      = 20;
	localparam int DIV_STEPS  = 20;
	localparam int DIV_CW     = 5;
	localparam int REM_W      = 4;
	localparam int GAIN_W     = 17;
	localparam int PROD_W     = 42;
	localparam int IN_W       = CHANNELS * SMP_W;
	localparam int OUTD_W     = CHANNELS * OUT_W;

	localparam logic [1:0] REG_TRIM = 2'd0;
	localparam logic [1:0] REG_WIN  = 2'd1;
	localparam logic [1:0] REG_LAG  = 2'd2;
	localparam logic [1:0] REG_GAIN = 2'd3;

	localparam logic [CNT_W-1:0]  WIN_MIN   = 4'd3;
	localparam logic [CNT_W-1:0]  WIN_MAX   = 4'd8;
	localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;

	typedef struct packed {
		logic              trim;
		logic [CNT_W-1:0]  win;
		logic              lag;
		logic [GAIN_W-1:0] gain;
	} cfg_t;

	typedef struct packed {
		logic             load;
		logic             win_wr;
		logic             raw;
		logic             rd;
		logic             rd_first;
		logic             div_start;
		logic             div_fin;
		logic             mul;
		logic             lag;
		logic             publish;
		logic [CH_W-1:0]  ch;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic             trim;
		logic [CNT_W-1:0] fill;
		logic             div_done;
		logic             out_free;
	} sts_t;

endpackage

@@ src/imu_trimmed_mean_lag_filter.sv @@
// Per channel, with trimming on: write the sample into the window, scan the n filled entries
// (up to 8), divide in the 20-step divider, then multiply and lag; with trimming off the raw
// sample goes straight to the multiply and lag. All six channels run in turn before publish.
// A new input beat is taken once the previous one has been processed, even while its
// result still waits on the master side. Reset (arst_n low, asynchronous): registers
// return to their defaults, windows empty, lag history zero, no result pending.
module imu_trimmed_mean_lag_filter (
	input  logic          clk,
	input  logic          arst_n,
	// fields from bit 0: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [95:0]   s_tdata,
	// fields from bit 0: filtered_accel_x, _y, _z, filtered_gyro_x, _y, _z
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [143:0]  m_tdata,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	imf_pkg::cfg_t cfg;
	imf_pkg::cmd_t cmd;
	imf_pkg::sts_t sts;
	logic          win_clr;

	// Register file; a valid window-size write empties every window.
	imf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.win_clr (win_clr)
	);

	// Sequencer: walk the channels, scan each window and divide when trimming is on, then smooth.
	imf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Window memory, accumulator, divider, lag multiplier and output register.
	imf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.win_clr   (win_clr),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

@@ src/imf_cfg.sv @@
module imf_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output imf_pkg::cfg_t       cfg,
	output logic                win_clr
);

	logic                          wr_en;
	logic [imf_pkg::CNT_W-1:0]     win_wd;
	logic [imf_pkg::GAIN_W-1:0]    gain_wd;
	logic                          win_ok;
	logic                          gain_ok;
	imf_pkg::cfg_t                 cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign win_wd  = pwdata[imf_pkg::CNT_W-1:0];
	assign gain_wd = pwdata[imf_pkg::GAIN_W-1:0];
	assign win_ok  = (win_wd >= imf_pkg::WIN_MIN) && (win_wd <= imf_pkg::WIN_MAX);
	assign gain_ok = gain_wd <= imf_pkg::GAIN_ONE;
	assign win_clr = wr_en && (paddr[3:2] == imf_pkg::REG_WIN) && win_ok;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trim <= 1'b1;
			cfg_q.win  <= 4'd5;
			cfg_q.lag  <= 1'b1;
			cfg_q.gain <= 17'd13107;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				imf_pkg::REG_TRIM: cfg_q.trim <= pwdata[0];
				imf_pkg::REG_WIN: begin
					if (win_ok) cfg_q.win <= win_wd;
				end
				imf_pkg::REG_LAG:  cfg_q.lag <= pwdata[0];
				imf_pkg::REG_GAIN: begin
					if (gain_ok) cfg_q.gain <= gain_wd;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			imf_pkg::REG_TRIM: prdata[0] = cfg_q.trim;
			imf_pkg::REG_WIN:  prdata[imf_pkg::CNT_W-1:0] = cfg_q.win;
			imf_pkg::REG_LAG:  prdata[0] = cfg_q.lag;
			imf_pkg::REG_GAIN: prdata[imf_pkg::GAIN_W-1:0] = cfg_q.gain;
			default: prdata = '0;
		endcase
	end

endmodule

@@ src/imf_dp.sv @@
module imf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  imf_pkg::cfg_t                 cfg,
	input  logic                          win_clr,
	input  imf_pkg::cmd_t                 cmd,
	output imf_pkg::sts_t                 sts,
	input  logic [imf_pkg::IN_W-1:0]      in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [imf_pkg::OUTD_W-1:0]    out_data
);

	localparam int CH = imf_pkg::CHANNELS;

	logic signed [imf_pkg::SMP_W-1:0]  smp_q [CH];
	logic [imf_pkg::IDX_W-1:0]         pos_q [CH];
	logic [imf_pkg::CNT_W-1:0]         fill_q [CH];
	logic signed [imf_pkg::OUT_W-1:0]  prev_q [CH];
	logic signed [imf_pkg::OUT_W-1:0]  res_q [CH];
	logic signed [imf_pkg::SMP_W-1:0]  mem [imf_pkg::MEM_DEPTH];

	logic signed [imf_pkg::SMP_W-1:0]  rd_s1;
	logic                              rdv_s1;
	logic                              first_s1;
	logic signed [imf_pkg::SUM_W-1:0]  sum_q;
	logic signed [imf_pkg::SMP_W-1:0]  lo_q;
	logic signed [imf_pkg::SMP_W-1:0]  hi_q;

	logic [imf_pkg::DIV_CW-1:0]        div_cnt_q;
	logic [imf_pkg::SUM_W-1:0]         quo_q;
	logic [imf_pkg::REM_W-1:0]         rem_q;
	logic [imf_pkg::REM_W-1:0]         den_q;
	logic                              neg_q;
	logic signed [imf_pkg::SMP_W-1:0]  mean_q;
	logic signed [imf_pkg::PROD_W-1:0] prod_q;
	logic                              out_valid_q;
	logic [imf_pkg::OUTD_W-1:0]        out_data_q;

	logic [imf_pkg::IDX_W-1:0]         wpos;
	logic [imf_pkg::IDX_W-1:0]         npos;
	logic [imf_pkg::CNT_W-1:0]         nfill;
	logic signed [imf_pkg::SUM_W-1:0]  num;
	logic [imf_pkg::SUM_W-1:0]         mag;
	logic [imf_pkg::REM_W-1:0]         den;
	logic [imf_pkg::REM_W-1:0]         rem_sh;
	logic signed [imf_pkg::OUT_W-1:0]  xval;
	logic signed [imf_pkg::OUT_W:0]    dval;
	logic signed [imf_pkg::OUT_W-1:0]  yval;
	logic [imf_pkg::SMP_W-1:0]         quo_lo;

	always_comb begin
		wpos  = ({1'b0, pos_q[cmd.ch]} >= cfg.win) ? '0 : pos_q[cmd.ch];
		npos  = (({1'b0, wpos} + 4'd1) == cfg.win) ? '0 : wpos + 3'd1;
		nfill = (fill_q[cmd.ch] < cfg.win) ? fill_q[cmd.ch] + 4'd1 : fill_q[cmd.ch];
		if (fill_q[cmd.ch] <= 4'd2) begin
			num = sum_q;
			den = fill_q[cmd.ch];
		end else begin
			num = sum_q - imf_pkg::SUM_W'(lo_q) - imf_pkg::SUM_W'(hi_q);
			den = fill_q[cmd.ch] - 4'd2;
		end
		mag    = num[imf_pkg::SUM_W-1] ? imf_pkg::SUM_W'(-num) : imf_pkg::SUM_W'(num);
		rem_sh = {rem_q[imf_pkg::REM_W-2:0], quo_q[imf_pkg::SUM_W-1]};
		quo_lo = quo_q[imf_pkg::SMP_W-1:0];
		xval   = {mean_q, 8'h00};
		dval   = {xval[imf_pkg::OUT_W-1], xval}
			- {prev_q[cmd.ch][imf_pkg::OUT_W-1], prev_q[cmd.ch]};
		yval   = cfg.lag
			? prev_q[cmd.ch] + imf_pkg::OUT_W'(prod_q >>> 16)
			: xval;
	end

	// Window memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.win_wr) mem[{cmd.ch, wpos}] <= smp_q[cmd.ch];
		if (cmd.rd) rd_s1 <= mem[{cmd.ch, cmd.idx}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CH; i++) begin
				pos_q[i]  <= '0;
				fill_q[i] <= '0;
				prev_q[i] <= '0;
			end
			rdv_s1      <= 1'b0;
			first_s1    <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rdv_s1   <= cmd.rd;
			first_s1 <= cmd.rd_first;
			if (win_clr) begin
				for (int i = 0; i < CH; i++) begin
					pos_q[i]  <= '0;
					fill_q[i] <= '0;
				end
			end else if (cmd.win_wr) begin
				pos_q[cmd.ch]  <= npos;
				fill_q[cmd.ch] <= nfill;
			end
			if (cmd.div_start) div_cnt_q <= imf_pkg::DIV_CW'(imf_pkg::DIV_STEPS);
			else if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - 5'd1;
			if (cmd.lag) prev_q[cmd.ch] <= yval;
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < CH; i++) smp_q[i] <= in_data[i*imf_pkg::SMP_W +: imf_pkg::SMP_W];
		end
		if (rdv_s1) begin
			if (first_s1) begin
				sum_q <= imf_pkg::SUM_W'(rd_s1);
				lo_q  <= rd_s1;
				hi_q  <= rd_s1;
			end else begin
				sum_q <= sum_q + imf_pkg::SUM_W'(rd_s1);
				if (rd_s1 < lo_q) lo_q <= rd_s1;
				if (rd_s1 > hi_q) hi_q <= rd_s1;
			end
		end
		if (cmd.div_start) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[imf_pkg::SUM_W-1];
		end else if (div_cnt_q != '0) begin
			if (rem_sh >= den_q) begin
				rem_q <= rem_sh - den_q;
				quo_q <= {quo_q[imf_pkg::SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[imf_pkg::SUM_W-2:0], 1'b0};
			end
		end
		if (cmd.div_fin) mean_q <= neg_q ? -quo_lo : quo_lo;
		else if (cmd.raw) mean_q <= smp_q[cmd.ch];
		if (cmd.mul) prod_q <= dval * $signed({1'b0, cfg.gain});
		if (cmd.lag) res_q[cmd.ch] <= yval;
		if (cmd.publish) begin
			for (int i = 0; i < CH; i++) out_data_q[i*imf_pkg::OUT_W +: imf_pkg::OUT_W] <= res_q[i];
		end
	end

	assign sts.trim     = cfg.trim;
	assign sts.fill     = fill_q[cmd.ch];
	assign sts.div_done = div_cnt_q == '0;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;

endmodule

@@ src/imf_ctrl.sv @@
module imf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  imf_pkg::sts_t  sts,
	output imf_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_CH, S_SCAN, S_SCAN_END, S_DIV_ST, S_DIV, S_DIV_FIN, S_MUL, S_LAG, S_OUT
	} state_t;

	state_t                    state_q;
	logic [imf_pkg::CH_W-1:0]  ch_q;
	logic [imf_pkg::IDX_W-1:0] idx_q;
	logic                      scan_last;

	assign in_ready  = state_q == S_IDLE;
	assign scan_last = ({1'b0, idx_q} + 4'd1) >= sts.fill;

	always_comb begin
		cmd          = '0;
		cmd.ch       = ch_q;
		cmd.idx      = idx_q;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.win_wr   = (state_q == S_CH) && sts.trim;
		cmd.raw      = (state_q == S_CH) && !sts.trim;
		cmd.rd       = state_q == S_SCAN;
		cmd.rd_first = (state_q == S_SCAN) && (idx_q == '0);
		cmd.div_start = state_q == S_DIV_ST;
		cmd.div_fin  = state_q == S_DIV_FIN;
		cmd.mul      = state_q == S_MUL;
		cmd.lag      = state_q == S_LAG;
		cmd.publish  = (state_q == S_OUT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q    <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					ch_q <= '0;
					if (in_valid) state_q <= S_CH;
				end
				S_CH: begin
					idx_q   <= '0;
					state_q <= sts.trim ? S_SCAN : S_MUL;
				end
				S_SCAN: begin
					idx_q <= idx_q + 3'd1;
					if (scan_last) state_q <= S_SCAN_END;
				end
				S_SCAN_END: state_q <= S_DIV_ST;
				S_DIV_ST:   state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done) state_q <= S_DIV_FIN;
				end
				S_DIV_FIN:  state_q <= S_MUL;
				S_MUL:      state_q <= S_LAG;
				S_LAG: begin
					if (ch_q == imf_pkg::CH_W'(imf_pkg::CHANNELS - 1)) begin
						state_q <= S_OUT;
					end else begin
						ch_q    <= ch_q + 3'd1;
						state_q <= S_CH;
					end
				end
				S_OUT: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		ch_q <= imf_pkg::CH_W'(imf_pkg::CHANNELS - 1))
		else $error("channel index out of range");
	a_pub_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> sts.out_free)
		else $error("publish over an untaken result");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_FIN) |-> $past(sts.div_done))
		else $error("divider left before done");
	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ({1'b0, idx_q} < sts.fill))
		else $error("scan beyond filled entries");

endmodule

@@ verif/tb.sv @@
module tb;

	logic                        clk;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [imf_pkg::IN_W-1:0]    s_tdata;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [imf_pkg::OUTD_W-1:0]  m_tdata;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [3:0]                  paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;

	// beat counts, used only to wait for the result stream to drain
	int sent_beats;
	int got_beats;

	imu_trimmed_mean_lag_filter dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Filter predictor: its own copy of the registers, windows and lag history.
	// Each accepted sample beat is turned into the expected filtered beat right away.
	class imu_filter_board;
		bit                                  trim_on;
		logic [imf_pkg::CNT_W-1:0]           win_len;
		bit                                  lag_on;
		logic [imf_pkg::GAIN_W-1:0]          alpha;
		logic signed [imf_pkg::SMP_W-1:0]    ring [imf_pkg::CHANNELS][imf_pkg::MAX_WINDOW];
		int                                  wr_pos [imf_pkg::CHANNELS];
		int                                  fill [imf_pkg::CHANNELS];
		longint                              last_out [imf_pkg::CHANNELS];
		logic [imf_pkg::OUTD_W-1:0]          pending_filtered [$];
		int                                  errors;

		function new();
			errors = 0;
			trim_on = 1;
			win_len = 5;
			lag_on = 1;
			alpha = 13107;
			flush_windows();
			foreach (last_out[c]) last_out[c] = 0;
		endfunction

		function void flush_windows();
			foreach (ring[c, i]) ring[c][i] = '0;
			foreach (wr_pos[c]) begin
				wr_pos[c] = 0;
				fill[c] = 0;
			end
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				imf_pkg::REG_TRIM: trim_on = val[0];
				imf_pkg::REG_WIN: begin
					if (val[3:0] >= imf_pkg::WIN_MIN && val[3:0] <= imf_pkg::WIN_MAX) begin
						win_len = val[3:0];
						flush_windows();
					end
				end
				imf_pkg::REG_LAG: lag_on = val[0];
				imf_pkg::REG_GAIN: begin
					if (val[16:0] <= imf_pkg::GAIN_ONE) alpha = val[16:0];
				end
			endcase
		endfunction

		// drop one minimum and one maximum when more than two entries, truncate toward zero
		function longint trimmed_mean(int c, int n);
			longint lo, hi, sum, v;
			lo = ring[c][0];
			hi = ring[c][0];
			sum = 0;
			for (int i = 0; i < n; i++) begin
				v = ring[c][i];
				if (v < lo) lo = v;
				if (v > hi) hi = v;
				sum += v;
			end
			if (n <= 2) return sum / n;
			return (sum - lo - hi) / (n - 2);
		endfunction

		function void note_sample(logic [imf_pkg::IN_W-1:0] beat);
			logic [imf_pkg::OUTD_W-1:0] exp_beat;
			longint s, x, y, d, p, sh;
			int w, pos;
			w = win_len;
			exp_beat = '0;
			for (int c = 0; c < imf_pkg::CHANNELS; c++) begin
				s = $signed(beat[c*imf_pkg::SMP_W +: imf_pkg::SMP_W]);
				if (trim_on) begin
					pos = wr_pos[c];
					if (pos >= w) pos = 0;
					ring[c][pos] = s[imf_pkg::SMP_W-1:0];
					if (fill[c] < w) fill[c]++;
					wr_pos[c] = (pos + 1) % w;
					s = trimmed_mean(c, fill[c]);
				end
				x = s * 256;
				if (lag_on) begin
					d = x - last_out[c];
					p = d * longint'(alpha);
					sh = p >>> 16; // arithmetic shift floors
					y = last_out[c] + sh;
				end else begin
					y = x;
				end
				y = longint'($signed(y[31:0]));
				last_out[c] = y;
				exp_beat[c*imf_pkg::OUT_W +: imf_pkg::OUT_W] = y[imf_pkg::OUT_W-1:0];
			end
			pending_filtered.push_back(exp_beat);
		endfunction

		function void check_filtered(logic [imf_pkg::OUTD_W-1:0] got);
			logic [imf_pkg::OUTD_W-1:0] want;
			if (pending_filtered.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			want = pending_filtered.pop_front();
			for (int c = 0; c < imf_pkg::CHANNELS; c++) begin
				if (got[c*imf_pkg::OUT_W +: imf_pkg::OUT_W]
						!== want[c*imf_pkg::OUT_W +: imf_pkg::OUT_W]) begin
					$display("%0t: channel %0d expected %h actual %h", $time, c,
						want[c*imf_pkg::OUT_W +: imf_pkg::OUT_W],
						got[c*imf_pkg::OUT_W +: imf_pkg::OUT_W]);
					errors++;
				end
			end
		endfunction
	endclass

	imu_filter_board board;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sink side: draw a stall before each beat, check on the rising edge
	initial begin
		int stall;
		m_tready = 1'b0;
		got_beats = 0;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0) stall = 0;
			@(negedge clk);
			m_tready = 1'b0;
			repeat (stall) @(negedge clk);
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_filtered(m_tdata);
			got_beats++;
		end
	end

	// register write: setup cycle then access cycle, all at falling edges
	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (pready) board.write_reg(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// hold s_tvalid until the beat is taken; keep it high for a back-to-back beat
	task automatic send_sample(logic [imf_pkg::IN_W-1:0] beat, bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = beat;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_sample(beat);
		sent_beats++;
		@(negedge clk);
	endtask

	function automatic logic [imf_pkg::SMP_W-1:0] rnd_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 40)) - 16'd20;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [imf_pkg::IN_W-1:0] rnd_beat();
		logic [imf_pkg::IN_W-1:0] b;
		for (int c = 0; c < imf_pkg::CHANNELS; c++) begin
			b[c*imf_pkg::SMP_W +: imf_pkg::SMP_W] = rnd_sample();
		end
		return b;
	endfunction

	// drain results, then let the filter settle before touching registers
	task automatic drain();
		s_tvalid = 1'b0;
		while (got_beats != sent_beats) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	task automatic directed_phase();
		logic [imf_pkg::IN_W-1:0] b;
		// extremes: all max, all min, alternating, zero, minus one
		send_sample({imf_pkg::CHANNELS{16'h7FFF}}, 0);
		send_sample({imf_pkg::CHANNELS{16'h8000}}, 0);
		send_sample({3{16'h8000, 16'h7FFF}}, 1);
		send_sample('0, 0);
		send_sample({imf_pkg::CHANNELS{16'hFFFF}}, 1);
		// fill past the window so the ring wraps
		for (int i = 0; i < 6; i++) send_sample(rnd_beat(), i[0]);
		drain();
		// invalid window and gain writes are ignored
		reg_write(imf_pkg::REG_WIN, 32'd2);
		reg_write(imf_pkg::REG_WIN, 32'd9);
		reg_write(imf_pkg::REG_WIN, 32'd15);
		reg_write(imf_pkg::REG_GAIN, 32'd65537);
		reg_write(imf_pkg::REG_GAIN, 32'h1FFFF);
		for (int i = 0; i < 4; i++) send_sample(rnd_beat(), 0);
		drain();
		// trimming off, lag pass-through, then full and zero gain
		reg_write(imf_pkg::REG_TRIM, 32'd0);
		reg_write(imf_pkg::REG_LAG, 32'd0);
		send_sample({imf_pkg::CHANNELS{16'h8000}}, 0);
		send_sample({imf_pkg::CHANNELS{16'h7FFF}}, 0);
		drain();
		reg_write(imf_pkg::REG_LAG, 32'd1);
		reg_write(imf_pkg::REG_GAIN, 32'd65536);
		send_sample(rnd_beat(), 0);
		drain();
		reg_write(imf_pkg::REG_GAIN, 32'd0);
		b = rnd_beat();
		send_sample(b, 0);
		drain();
	endtask

	initial begin
		logic [31:0] gains [4];
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sent_beats = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		directed_phase();

		gains = '{32'd0, 32'd1, 32'd65536, 32'd65535};
		// random phases, each with its own settings; the smallest and largest
		// windows and gains come first
		for (int ph = 0; ph < 16; ph++) begin
			reg_write(imf_pkg::REG_TRIM, ($urandom_range(0, 4) != 0) ? 32'd1 : 32'd0);
			case (ph)
				0: reg_write(imf_pkg::REG_WIN, 32'd3);
				1: reg_write(imf_pkg::REG_WIN, 32'd8);
				default: reg_write(imf_pkg::REG_WIN, 32'($urandom_range(2, 9)));
			endcase
			reg_write(imf_pkg::REG_LAG, ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);
			if (ph < 4) reg_write(imf_pkg::REG_GAIN, gains[ph]);
			else reg_write(imf_pkg::REG_GAIN, 32'($urandom_range(0, 65540)));
			for (int i = 0; i < 50; i++) begin
				send_sample(rnd_beat(), $urandom_range(0, 3) == 0);
			end
			drain();
		end

		s_tvalid = 1'b0;
		while (got_beats != sent_beats) @(negedge clk);
		repeat (300) @(negedge clk);
		if (board.errors == 0 && board.pending_filtered.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// ~820 beats plus drains: far under this bound
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
